// ----- hw/rtl/slc_pkg.sv -----
// shared types and constants for the sorted list engine
package slc_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VALUE_W = 32;
    localparam int POS_W = 6;
    localparam int ENTRY_COUNT_W = 7;
    localparam int IDX_CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CNT_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        REQ_INSERT     = 2'd0,
        REQ_REMOVE_VAL = 2'd1,
        REQ_READ_POS   = 2'd2,
        REQ_REMOVE_POS = 2'd3
    } req_code_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] read_value;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
    } rsp_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                      compare;
        logic                      by_position;
        logic                      apply_ins;
        logic                      apply_del;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/slc_cell.sv -----
// one storage cell of the sorted chain: holds an entry and shifts with its neighbors
module slc_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  slc_pkg::cell_ctrl_t                 ctrl,
    input  logic [slc_pkg::IDX_W-1:0]           cell_idx,
    input  logic                                occupied,
    input  logic                                prev_before,
    input  logic signed [slc_pkg::VALUE_W-1:0]  prev_entry,
    input  logic signed [slc_pkg::VALUE_W-1:0]  next_entry,
    output logic signed [slc_pkg::VALUE_W-1:0]  entry,
    output logic                                ahead,
    output logic                                hit,
    output logic signed [slc_pkg::VALUE_W-1:0]  tap
);

    localparam int CmpW = slc_pkg::IDX_CMP_W;

    logic signed [slc_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic before_reg, before_next;
    logic equal_reg, equal_next;
    logic at_point;

    // first cell not ahead of the insert or remove point
    assign at_point = !before_reg && prev_before;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.apply_ins && !before_reg)
        begin
            entry_next = at_point ? ctrl.value : prev_entry;
        end
        else if (ctrl.apply_del && !before_reg)
        begin
            entry_next = next_entry;
        end
    end

    always_comb
    begin
        before_next = before_reg;
        equal_next  = equal_reg;
        if (ctrl.compare)
        begin
            equal_next = (entry_reg == ctrl.value);
            if (ctrl.by_position)
            begin
                before_next = CmpW'(cell_idx) < CmpW'(ctrl.position);
            end
            else
            begin
                before_next = occupied && (entry_reg > ctrl.value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg <= 1'b0;
            equal_reg  <= 1'b0;
        end
        else
        begin
            before_reg <= before_next;
            equal_reg  <= equal_next;
        end
    end

    assign entry  = entry_reg;
    assign ahead  = before_reg;
    assign hit    = at_point && occupied && equal_reg;
    assign tap    = at_point ? entry_reg : '0;

endmodule

// ----- hw/rtl/sorted_list_engine_top.sv -----
// sorted list engine: request sequencer over a chain of storage cells
// Holds up to CAPACITY signed values in descending order, largest at position 0.
// Request channel (req, req_valid, req_stall): insert a value, remove a value,
// read at a position or remove at a position. Response channel (rsp, rsp_valid,
// rsp_stall): one item per request with ok, read_value and the entry count.
// An item is taken at a clock edge with valid high and stall low.
// Each request walks four steps: accept, every cell compares against the
// request in parallel, the insert or remove point and its entry are resolved,
// then the cells at and past the point shift one place toward or away from
// it at once, if an insert or remove succeeds. The response is registered in
// the shift step, and no new request is accepted until the sequencer is idle.
// The response register sits between the sides, so a new request is accepted
// while a response waits; the shift step holds until that register is free, so
// a stalled receiver delays the following request and never loses a response.
// Reset empties the store at once: the count goes to zero and no cell needs
// clearing, since no entry at or beyond the count is ever read.
module sorted_list_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  slc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output slc_pkg::rsp_t rsp
);

    localparam int Cap  = slc_pkg::CAPACITY;
    localparam int CntW = slc_pkg::CNT_W;
    localparam int IdxW = slc_pkg::IDX_W;
    localparam int ValW = slc_pkg::VALUE_W;
    localparam int EcW  = slc_pkg::ENTRY_COUNT_W;
    localparam int CcW  = slc_pkg::CNT_CMP_W;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_COMPARE = 4'b0010,
        S_DECIDE  = 4'b0100,
        S_APPLY   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    slc_pkg::req_t req_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic ok_reg, ok_next;
    logic signed [ValW-1:0] rv_reg, rv_next;
    logic rsp_valid_reg, rsp_valid_next;
    slc_pkg::rsp_t rsp_reg, rsp_next;

    slc_pkg::cell_ctrl_t ctrl;
    logic signed [ValW-1:0] entry_vec [Cap];
    logic signed [ValW-1:0] tap_vec [Cap];
    logic [Cap-1:0] before_vec, hit_vec, occ_vec;

    logic req_take, rsp_free, apply_go, is_pos, pos_ok, found;
    logic signed [ValW-1:0] tap_or;

    assign req_take = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign apply_go = (state_reg == S_APPLY) && rsp_free;
    assign req_stall = (state_reg != S_IDLE);
    assign is_pos = (req_reg.req_type == slc_pkg::REQ_READ_POS)
                 || (req_reg.req_type == slc_pkg::REQ_REMOVE_POS);
    assign pos_ok = CcW'(req_reg.position) < CcW'(count_reg);

    always_comb
    begin
        ctrl.compare     = (state_reg == S_COMPARE);
        ctrl.by_position = is_pos;
        ctrl.value       = req_reg.value;
        ctrl.position    = req_reg.position;
        ctrl.apply_ins   = apply_go && ok_reg
                        && (req_reg.req_type == slc_pkg::REQ_INSERT);
        ctrl.apply_del   = apply_go && ok_reg
                        && ((req_reg.req_type == slc_pkg::REQ_REMOVE_VAL)
                         || (req_reg.req_type == slc_pkg::REQ_REMOVE_POS));
    end

    for (genvar g = 0; g < Cap; g++)
    begin : g_cell
        assign occ_vec[g] = CntW'(g) < count_reg;

        slc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cell_idx    (IdxW'(g)),
            .occupied    (occ_vec[g]),
            .prev_before ((g == 0) ? 1'b1 : before_vec[(g == 0) ? 0 : g - 1]),
            .prev_entry  ((g == 0) ? ValW'(0) : entry_vec[(g == 0) ? 0 : g - 1]),
            .next_entry  ((g == Cap - 1) ? ValW'(0)
                                         : entry_vec[(g == Cap - 1) ? g : g + 1]),
            .entry       (entry_vec[g]),
            .ahead       (before_vec[g]),
            .hit         (hit_vec[g]),
            .tap         (tap_vec[g])
        );
    end

    // only the cell at the point drives a nonzero tap
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < Cap; i++)
        begin
            tap_or = tap_or | tap_vec[i];
        end
    end

    assign found = |hit_vec;

    always_comb
    begin
        ok_next = ok_reg;
        rv_next = rv_reg;
        if (state_reg == S_DECIDE)
        begin
            unique case (req_reg.req_type)
                slc_pkg::REQ_INSERT:     ok_next = count_reg < CntW'(Cap);
                slc_pkg::REQ_REMOVE_VAL: ok_next = found;
                default:                 ok_next = pos_ok;
            endcase
            rv_next = (is_pos && pos_ok) ? tap_or : '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.apply_ins)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (ctrl.apply_del)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (req_take) state_next = S_COMPARE;
            S_COMPARE: state_next = S_DECIDE;
            S_DECIDE:  state_next = S_APPLY;
            S_APPLY:   if (rsp_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (apply_go)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.ok          = ok_reg;
            rsp_next.read_value  = rv_reg;
            rsp_next.entry_count = EcW'(count_next);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        ok_reg  <= ok_next;
        rv_reg  <= rv_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Cap))
        else $error("entry count beyond capacity");

    a_count_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_APPLY))
        else $error("entry count changed outside the shift step");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.ok) |-> (rsp_reg.read_value == '0))
        else $error("failed request returned a nonzero value");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> (rsp_reg.entry_count == EcW'(count_reg)))
        else $error("response count differs from held count");

endmodule

// ----- tb/sorted_list_engine_tb.sv -----
// testbench for the sorted list engine: directed and random requests checked against a queue model
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    slc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    slc_pkg::rsp_t rsp;

    // descending copy of the store, largest first
    logic signed [slc_pkg::VALUE_W-1:0] list_model[$];
    slc_pkg::rsp_t expected_rsp[$];
    slc_pkg::rsp_t want_rsp;

    int fail_count = 0;
    int cycle_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int full_rejects = 0;
    int peak_count = 0;
    int hold_request = 0;
    int stall_left = 0;
    int recv_steady_left = 0;
    int send_steady_left = 0;
    bit sender_steady = 1'b0;

    sorted_list_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_rsp.size());
            $display("FAIL");
            $finish;
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    function automatic slc_pkg::rsp_t predict_response(input slc_pkg::req_t r);
        slc_pkg::rsp_t res;
        logic signed [slc_pkg::VALUE_W-1:0] v;
        int i;
        res = '0;
        v = r.value;
        i = 0;
        unique case (r.req_type)
            slc_pkg::REQ_INSERT:
            begin
                if (list_model.size() < slc_pkg::CAPACITY)
                begin
                    // new value goes ahead of equal entries
                    while (i < list_model.size() && list_model[i] > v)
                        i++;
                    list_model.insert(i, v);
                    res.ok = 1'b1;
                end
            end
            slc_pkg::REQ_REMOVE_VAL:
            begin
                while (i < list_model.size() && list_model[i] > v)
                    i++;
                if (i < list_model.size() && list_model[i] == v)
                begin
                    list_model.delete(i);
                    res.ok = 1'b1;
                end
            end
            slc_pkg::REQ_READ_POS:
            begin
                if (int'(r.position) < list_model.size())
                begin
                    res.read_value = list_model[r.position];
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                if (int'(r.position) < list_model.size())
                begin
                    res.read_value = list_model[r.position];
                    list_model.delete(r.position);
                    res.ok = 1'b1;
                end
            end
        endcase
        res.entry_count = slc_pkg::ENTRY_COUNT_W'(list_model.size());
        return res;
    endfunction

    function automatic slc_pkg::req_t make_req(input slc_pkg::req_code_t code,
                                               input logic [slc_pkg::VALUE_W-1:0] v,
                                               input int pos);
        slc_pkg::req_t r;
        r.req_type = code;
        r.value = v;
        r.position = slc_pkg::POS_W'(pos);
        return r;
    endfunction

    function automatic slc_pkg::req_t random_req(input int w_ins, input int w_rmv,
                                                 input int w_rd, input int w_rpos);
        slc_pkg::req_t r;
        int sel;
        int n;
        logic [slc_pkg::VALUE_W-1:0] extremes[6];
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_fffe,
                     32'h0000_0000, 32'hffff_ffff};
        n = list_model.size();
        // values: held entries and their neighbors so removes hit, plus a spread
        sel = $urandom_range(0, 99);
        if (sel < 35 && n > 0)
            r.value = list_model[$urandom_range(0, n - 1)];
        else if (sel < 50 && n > 0)
            r.value = list_model[$urandom_range(0, n - 1)] + (int'($urandom_range(0, 2)) - 1);
        else if (sel < 65)
            r.value = int'($urandom_range(0, 16)) - 8;
        else if (sel < 75)
            r.value = extremes[$urandom_range(0, 5)];
        else
            r.value = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 70 && n > 0)
            r.position = slc_pkg::POS_W'($urandom_range(0, n - 1));
        else if (sel < 80 && n < 64)
            r.position = slc_pkg::POS_W'(n);
        else
            r.position = slc_pkg::POS_W'($urandom_range(0, 63));
        sel = $urandom_range(0, w_ins + w_rmv + w_rd + w_rpos - 1);
        if (sel < w_ins)
            r.req_type = slc_pkg::REQ_INSERT;
        else if (sel < w_ins + w_rmv)
            r.req_type = slc_pkg::REQ_REMOVE_VAL;
        else if (sel < w_ins + w_rmv + w_rd)
            r.req_type = slc_pkg::REQ_READ_POS;
        else
            r.req_type = slc_pkg::REQ_REMOVE_POS;
        return r;
    endfunction

    task automatic send_req(input slc_pkg::req_t r);
        slc_pkg::rsp_t want;
        int gap;
        @(negedge clk);
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        want = predict_response(r);
        expected_rsp.push_back(want);
        sent_count++;
        if (r.req_type == slc_pkg::REQ_INSERT && !want.ok)
            full_rejects++;
        if (list_model.size() > peak_count)
            peak_count = list_model.size();
        // keep valid high when the next item follows at once
        gap = 0;
        if (sender_steady)
            gap = 0;
        else if (send_steady_left > 0)
            send_steady_left--;
        else if ($urandom_range(0, 99) < 3)
            send_steady_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 99) < 35)
            gap = idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n, input int w_ins, input int w_rmv, input int w_rd,
                              input int w_rpos);
        repeat (n) send_req(random_req(w_ins, w_rmv, w_rd, w_rpos));
    endtask

    // receiver: random stalls, quiet stretches, and long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else if (recv_steady_left > 0)
        begin
            rsp_stall <= 1'b0;
            recv_steady_left--;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            recv_steady_left = $urandom_range(20, 80);
            rsp_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 70)
            rsp_stall <= 1'b0;
        else
        begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (expected_rsp.size() == 0)
                note_failure($sformatf("unexpected item: ok=%0b read_value=%0d count=%0d",
                                       rsp.ok, rsp.read_value, rsp.entry_count));
            else
            begin
                want_rsp = expected_rsp.pop_front();
                checked_count++;
                if (rsp.ok !== want_rsp.ok || rsp.read_value !== want_rsp.read_value ||
                    rsp.entry_count !== want_rsp.entry_count)
                    note_failure($sformatf(
                        "response %0d mismatch: ok %0b/%0b read_value %0d/%0d count %0d/%0d",
                        checked_count, want_rsp.ok, rsp.ok, want_rsp.read_value,
                        rsp.read_value, want_rsp.entry_count, rsp.entry_count));
            end
        end
    end

    task automatic test_empty_store();
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'd0, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_POS, 32'd0, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_VAL, 32'd0, 0));
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'hffff_ffff, 63));
    endtask

    task automatic test_extreme_values();
        send_req(make_req(slc_pkg::REQ_INSERT, 32'h7fff_ffff, 63));
        send_req(make_req(slc_pkg::REQ_INSERT, 32'h8000_0000, 0));
        send_req(make_req(slc_pkg::REQ_INSERT, 32'h0000_0000, 0));
        send_req(make_req(slc_pkg::REQ_INSERT, 32'hffff_ffff, 0));
        send_req(make_req(slc_pkg::REQ_INSERT, 32'd5, 0));
        // duplicate lands ahead of its equal
        send_req(make_req(slc_pkg::REQ_INSERT, 32'd5, 0));
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'd0, 0));
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'd0, 5));
        // position equal to the count
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'd0, 6));
        send_req(make_req(slc_pkg::REQ_REMOVE_VAL, 32'd5, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_VAL, 32'd7, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_VAL, 32'h8000_0000, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_POS, 32'd0, 0));
        send_req(make_req(slc_pkg::REQ_REMOVE_POS, 32'd0, 9));
        send_req(make_req(slc_pkg::REQ_READ_POS, 32'd0, 63));
    endtask

    task automatic test_mixed_traffic();
        run_random(700, 30, 25, 25, 20);
    endtask

    task automatic test_sender_pause();
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        run_random(400, 80, 5, 10, 5);
    endtask

    task automatic test_churn_at_capacity();
        run_random(300, 50, 15, 15, 20);
    endtask

    task automatic test_receiver_hold();
        hold_request = 300;
        sender_steady = 1'b1;
        run_random(40, 40, 20, 20, 20);
        sender_steady = 1'b0;
        run_random(160, 40, 20, 20, 20);
    endtask

    task automatic test_drain_store();
        run_random(300, 10, 40, 10, 40);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_store();
        test_extreme_values();
        test_mixed_traffic();
        test_sender_pause();
        test_fill_to_capacity();
        test_churn_at_capacity();
        test_receiver_hold();
        test_drain_store();
        wait_drained();
        $display("sent %0d requests, checked %0d responses in %0d cycles",
                 sent_count, checked_count, cycle_count);
        $display("store peaked at %0d entries, %0d inserts turned away as full",
                 peak_count, full_rejects);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
